// ----- hw/rtl/sliding_window_percentile_tracker_core_macros.svh -----
// Assertion macros for the sliding window percentile tracker.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef SLIDING_WINDOW_PERCENTILE_TRACKER_CORE_MACROS_SVH
`define SLIDING_WINDOW_PERCENTILE_TRACKER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define SWPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define SWPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWPT_ASSERT_NOW(label, ante, cons, msg)
`define SWPT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/swpt_pkg.sv -----
// Shared types and constants for the sliding window percentile tracker.
// No dependencies.
package swpt_pkg;

  localparam int TIME_W     = 24;
  localparam int COUNT_W    = 8;
  localparam int WINDOW_DEF = 128;

  // floor(u / 100) = (u * 5243) >> 19, exact for u below about 40000
  localparam int             DIV100_W     = 13;
  localparam logic [12:0]    DIV100_MUL   = 13'd5243;
  localparam int             DIV100_SHIFT = 19;
  localparam int             P99_BIAS     = 99;

  typedef struct packed {
    logic [TIME_W-1:0] tick_time;
    logic [TIME_W-1:0] render_time;
    logic [TIME_W-1:0] swap_time;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] sample_count;
    logic [TIME_W-1:0]  tick_median;
    logic [TIME_W-1:0]  tick_p99;
    logic [TIME_W-1:0]  tick_peak;
    logic [TIME_W-1:0]  render_median;
    logic [TIME_W-1:0]  render_p99;
    logic [TIME_W-1:0]  render_peak;
    logic [TIME_W-1:0]  swap_median;
    logic [TIME_W-1:0]  swap_p99;
    logic [TIME_W-1:0]  swap_peak;
  } out_item_t;

  // Status and results of one lane
  typedef struct packed {
    logic              idle;
    logic [TIME_W-1:0] median;
    logic [TIME_W-1:0] p99;
    logic [TIME_W-1:0] peak;
  } lane_res_t;

endpackage

// ----- hw/rtl/swpt_lane.sv -----
// One lane: sample ring plus a sorted copy kept by a single merge pass.
// Depends on swpt_pkg.
module swpt_lane import swpt_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  localparam int AW = $clog2(WINDOW),
  localparam int CW = $clog2(WINDOW + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] x,
  input  logic [AW-1:0]     slot,
  input  logic [CW-1:0]     old_count,
  input  logic [CW-1:0]     new_count,
  input  logic [AW-1:0]     med_idx,
  input  logic [AW-1:0]     p99_idx,
  input  logic [AW-1:0]     last_idx,
  output lane_res_t         res
);

  typedef enum logic [2:0] {
    L_IDLE, L_GETY, L_RD, L_EV, L_RMED, L_RP99, L_RLAST, L_RCAP
  } lane_state_t;

  logic [TIME_W-1:0] ring [WINDOW];
  logic [TIME_W-1:0] srt  [WINDOW];

  lane_state_t       state_r, state_nxt;
  logic [TIME_W-1:0] x_r, x_nxt;
  logic [TIME_W-1:0] y_r, y_nxt;
  logic              full_r, full_nxt;
  logic              asc_r, asc_nxt;
  logic              ins_pend_r, ins_pend_nxt;
  logic              rem_pend_r, rem_pend_nxt;
  logic [CW-1:0]     src_left_r, src_left_nxt;
  logic [CW-1:0]     dst_left_r, dst_left_nxt;
  logic [CW-1:0]     m_r, m_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [TIME_W-1:0] median_r, median_nxt;
  logic [TIME_W-1:0] p99_r, p99_nxt;
  logic [TIME_W-1:0] peak_r, peak_nxt;

  logic [TIME_W-1:0] ring_q_r;
  logic [TIME_W-1:0] srt_q_r;

  logic              have;
  logic              take_rem, take_ins, take_src, ins_ok;
  logic [CW-1:0]     rd_off, wr_off;
  logic [AW-1:0]     srt_ra, srt_wa;
  logic              srt_we;
  logic [TIME_W-1:0] srt_wd;

  always_comb begin
    have     = (src_left_r != '0);
    ins_ok   = asc_r ? (x_r <= srt_q_r) : (x_r >= srt_q_r);
    take_rem = have && rem_pend_r && (srt_q_r == y_r);
    take_ins = !take_rem && ins_pend_r && (!have || ins_ok);
    take_src = !take_rem && !take_ins && have;
    rd_off   = asc_r ? (m_r - src_left_r) : (src_left_r - CW'(1));
    wr_off   = asc_r ? (n_r - dst_left_r) : (dst_left_r - CW'(1));
    srt_we   = (state_r == L_EV) && (take_ins || take_src);
    srt_wd   = take_ins ? x_r : srt_q_r;
    srt_wa   = wr_off[AW-1:0];
    unique case (state_r)
      L_RMED:  srt_ra = med_idx;
      L_RP99:  srt_ra = p99_idx;
      L_RLAST: srt_ra = last_idx;
      default: srt_ra = rd_off[AW-1:0];
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    full_nxt     = full_r;
    asc_nxt      = asc_r;
    ins_pend_nxt = ins_pend_r;
    rem_pend_nxt = rem_pend_r;
    src_left_nxt = src_left_r;
    dst_left_nxt = dst_left_r;
    m_nxt        = m_r;
    n_nxt        = n_r;
    median_nxt   = median_r;
    p99_nxt      = p99_r;
    peak_nxt     = peak_r;
    unique case (state_r)
      L_IDLE: begin
        if (start) begin
          x_nxt     = x;
          m_nxt     = old_count;
          n_nxt     = new_count;
          full_nxt  = (old_count == CW'(WINDOW));
          state_nxt = L_GETY;
        end
      end
      L_GETY: begin
        // evicted value is valid only once the ring is full
        y_nxt        = ring_q_r;
        asc_nxt      = full_r && (ring_q_r <= x_r);
        ins_pend_nxt = 1'b1;
        rem_pend_nxt = full_r;
        src_left_nxt = m_r;
        dst_left_nxt = n_r;
        state_nxt    = L_RD;
      end
      L_RD: begin
        state_nxt = L_EV;
      end
      L_EV: begin
        if (take_rem) begin
          rem_pend_nxt = 1'b0;
        end
        if (take_ins) begin
          ins_pend_nxt = 1'b0;
        end
        if (take_rem || take_src) begin
          src_left_nxt = src_left_r - CW'(1);
        end
        if (take_ins || take_src) begin
          dst_left_nxt = dst_left_r - CW'(1);
        end
        state_nxt = (dst_left_nxt == '0) ? L_RMED : L_RD;
      end
      L_RMED: begin
        state_nxt = L_RP99;
      end
      L_RP99: begin
        median_nxt = srt_q_r;
        state_nxt  = L_RLAST;
      end
      L_RLAST: begin
        p99_nxt   = srt_q_r;
        state_nxt = L_RCAP;
      end
      L_RCAP: begin
        peak_nxt  = srt_q_r;
        state_nxt = L_IDLE;
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    full_r     <= full_nxt;
    asc_r      <= asc_nxt;
    ins_pend_r <= ins_pend_nxt;
    rem_pend_r <= rem_pend_nxt;
    src_left_r <= src_left_nxt;
    dst_left_r <= dst_left_nxt;
    m_r        <= m_nxt;
    n_r        <= n_nxt;
    median_r   <= median_nxt;
    p99_r      <= p99_nxt;
    peak_r     <= peak_nxt;
  end

  // Ring is read before write at the same slot, so ring_q_r holds the evicted sample
  always_ff @(posedge clk) begin
    ring_q_r <= ring[slot];
    if (start && state_r == L_IDLE) begin
      ring[slot] <= x;
    end
    srt_q_r <= srt[srt_ra];
    if (srt_we) begin
      srt[srt_wa] <= srt_wd;
    end
  end

  assign res.idle   = (state_r == L_IDLE);
  assign res.median = median_r;
  assign res.p99    = p99_r;
  assign res.peak   = peak_r;

endmodule

// ----- hw/rtl/sliding_window_percentile_tracker_core.sv -----
// From transfer to result: evicted-sample read, merge (n steps for n samples while
//   filling, n+1 once full), median, p99 and peak reads, then the output register.
// A new item is taken only after the previous result has left the lanes; the
//   per-lane sorted-store merge (one read, one write port, one comparator) sets the pace.
// Input stalls while busy. Reset clears fill count, write slot and control; sample
//   stores stay uncleared.
`include "sliding_window_percentile_tracker_core_macros.svh"
module sliding_window_percentile_tracker_core import swpt_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int UW = CW + 7;

  typedef enum logic {T_IDLE, T_BUSY} top_state_t;

  top_state_t    state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] n_r;
  logic [AW-1:0] slot_r;
  logic [AW-1:0] med_r, p99_r, last_r;
  logic          out_valid_r;
  out_item_t     out_data_r;

  logic                   accept;
  logic                   full;
  logic [CW-1:0]          count_nxt;
  logic [AW-1:0]          slot_nxt;
  logic [CW-1:0]          last;
  logic [UW-1:0]          bias_sum;
  logic [UW+DIV100_W-1:0] bias_prod;
  logic [CW-1:0]          p99_ceil;
  logic [CW-1:0]          p99_idx;
  logic                   all_idle;
  logic                   load_out;

  lane_res_t tick_res, render_res, swap_res;

  // Accept one transfer only when every lane has gone idle
  assign in_stall = (state_r != T_IDLE);
  assign accept   = in_valid && !in_stall;

  // Window bookkeeping: saturating fill count and wrapping write slot
  always_comb begin
    full      = (count_r == CW'(WINDOW));
    count_nxt = full ? count_r : count_r + CW'(1);
    slot_nxt  = (slot_r == AW'(WINDOW - 1)) ? '0 : slot_r + AW'(1);
  end

  // Rank indices for the new count n: last = n-1, median = last/2,
  // p99 = floor(99*last/100) = last - ceil(last/100)
  always_comb begin
    last      = full ? count_r - CW'(1) : count_r;
    bias_sum  = UW'(last) + UW'(P99_BIAS);
    bias_prod = bias_sum * DIV100_MUL;
    p99_ceil  = bias_prod[DIV100_SHIFT +: CW];
    p99_idx   = last - p99_ceil;
  end

  swpt_lane #(.WINDOW(WINDOW)) u_tick (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .x         (in_data.tick_time),
    .slot      (slot_r),
    .old_count (count_r),
    .new_count (count_nxt),
    .med_idx   (med_r),
    .p99_idx   (p99_r),
    .last_idx  (last_r),
    .res       (tick_res)
  );

  swpt_lane #(.WINDOW(WINDOW)) u_render (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .x         (in_data.render_time),
    .slot      (slot_r),
    .old_count (count_r),
    .new_count (count_nxt),
    .med_idx   (med_r),
    .p99_idx   (p99_r),
    .last_idx  (last_r),
    .res       (render_res)
  );

  swpt_lane #(.WINDOW(WINDOW)) u_swap (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .x         (in_data.swap_time),
    .slot      (slot_r),
    .old_count (count_r),
    .new_count (count_nxt),
    .med_idx   (med_r),
    .p99_idx   (p99_r),
    .last_idx  (last_r),
    .res       (swap_res)
  );

  assign all_idle = tick_res.idle && render_res.idle && swap_res.idle;
  // Move results to the output register once it is free; lanes hold them until then
  assign load_out = (state_r == T_BUSY) && all_idle && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      count_r     <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        T_IDLE: begin
          if (accept) begin
            count_r <= count_nxt;
            slot_r  <= slot_nxt;
            state_r <= T_BUSY;
          end
        end
        T_BUSY: begin
          if (load_out) begin
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    // Payload: capture ranks at the transfer, results when they leave the lanes
    if (accept) begin
      n_r    <= count_nxt;
      last_r <= last[AW-1:0];
      med_r  <= AW'(last >> 1);
      p99_r  <= p99_idx[AW-1:0];
    end
    if (load_out) begin
      out_data_r.sample_count  <= COUNT_W'(n_r);
      out_data_r.tick_median   <= tick_res.median;
      out_data_r.tick_p99      <= tick_res.p99;
      out_data_r.tick_peak     <= tick_res.peak;
      out_data_r.render_median <= render_res.median;
      out_data_r.render_p99    <= render_res.p99;
      out_data_r.render_peak   <= render_res.peak;
      out_data_r.swap_median   <= swap_res.median;
      out_data_r.swap_p99      <= swap_res.p99;
      out_data_r.swap_peak     <= swap_res.peak;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A transfer must only start lanes that are idle, and all of them must then run
  `SWPT_ASSERT_NOW(a_accept_idle, accept, all_idle, "transfer taken while a lane is busy")
  `SWPT_ASSERT_NEXT(a_lanes_start, accept, !all_idle, "lanes did not start after transfer")
  // Until the ring wraps, the write slot tracks the fill count
  `SWPT_ASSERT_NOW(a_slot_count, count_r != CW'(WINDOW), slot_r == AW'(count_r), "slot and count diverged")
  `SWPT_ASSERT_NOW(a_count_max, 1'b1, count_r <= CW'(WINDOW), "fill count beyond window")

endmodule
